[design/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg: segregated pool allocator shared definitions
// Sizes, codes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int POOL_PAGES  = 64;
  localparam int PAGE_BYTES  = 4096;
  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 32;
  localparam int CLS_W       = 4;
  localparam int PAGE_SHIFT  = 12;
  localparam int MIN_SHIFT   = 5;
  localparam int ADDR_PAGES  = (1 << ADDR_W) / PAGE_BYTES;
  localparam int PAGE_LIMIT  = (POOL_PAGES < ADDR_PAGES) ? POOL_PAGES : ADDR_PAGES;
  localparam int ADDR_PAGE_W = ADDR_W - PAGE_SHIFT;
  localparam int USED_W      = ADDR_PAGE_W + 1;
  localparam int PAGE_IDX_W  = $clog2(PAGE_LIMIT);
  localparam int SLOTS_PER_PAGE = PAGE_BYTES >> MIN_SHIFT;
  localparam int LINK_SLOTS  = PAGE_LIMIT * SLOTS_PER_PAGE;
  localparam int SLOT_W      = $clog2(LINK_SLOTS);
  localparam int IDX_W       = $clog2(SLOTS_PER_PAGE);
  localparam int LINK_W      = ADDR_W + 1;
  localparam int NUM_CLASSES = 8;
  localparam int HEAD_IDX_W  = $clog2(NUM_CLASSES);

  localparam logic [CLS_W-1:0]  CLS_FIRST  = 4'd5;
  localparam logic [CLS_W-1:0]  CLS_LAST   = 4'd12;
  localparam logic [SIZE_W-1:0] BULK_LIMIT = 32'd4088;
  localparam logic [ADDR_W-1:0] HDR_PAD    = 18'd8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NULL = 2'd1;
  localparam logic [1:0] STAT_BULK = 2'd2;
  localparam logic [1:0] STAT_OOP  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CARVE,
    S_ALLOC,
    S_POP,
    S_FREE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  // Size class of a small request: bit length of size+7, minimum class 5.
  function automatic logic [CLS_W-1:0] class_of(input logic [11:0] s);
    logic [11:0]      v;
    logic [CLS_W-1:0] n;
    v = s + 12'd7;
    n = '0;
    for (int i = 0; i < 12; i++) begin
      if (v[i]) n = CLS_W'(i + 1);
    end
    if (s <= 12'd8) n = CLS_FIRST;
    return n;
  endfunction

  function automatic logic [HEAD_IDX_W-1:0] head_index(input logic [CLS_W-1:0] c);
    return c[HEAD_IDX_W-1:0] - CLS_FIRST[HEAD_IDX_W-1:0];
  endfunction

endpackage

[design/spa_req_if.sv]
// ----------------------------------------------------------------------------
// spa_req_if: allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface spa_req_if import spa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, operation, request_size, free_address, input ready);
  modport sink   (input valid, operation, request_size, free_address, output ready);
endinterface

[design/spa_rsp_if.sv]
// ----------------------------------------------------------------------------
// spa_rsp_if: allocator response channel
// Valid/ready channel carrying one status, pointer and size class.
// ----------------------------------------------------------------------------
interface spa_rsp_if import spa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] result_address;
  logic [CLS_W-1:0]  size_class;

  modport source (output valid, status, result_address, size_class, input ready);
  modport sink   (input valid, status, result_address, size_class, output ready);
endinterface

[design/spa_link_mem.sv]
// ----------------------------------------------------------------------------
// spa_link_mem: free-list link storage
// One link per 32-byte slot; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spa_link_mem import spa_pkg::*; (
  input  logic              clk,
  input  link_wr_t          wr,
  input  logic [SLOT_W-1:0] raddr,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] links [LINK_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      links[wr.addr] <= wr.data;
    end
    rdata <= links[raddr];
  end

endmodule

[design/segregated_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// segregated_pool_allocator_unit: segregated free-list pool allocator
// Power-of-two classes 32..4096 bytes over a page pool, with page carving.
//
//   channel  dir  modport      carries
//   req      in   spa_req_if   operation, request_size, free_address
//   rsp      out  spa_rsp_if   status, result_address, size_class
//
// Allocate from a nonempty list passes DECODE, ALLOC and POP; a free passes
// DECODE and FREE; null and out-of-pool free answers come from DECODE; bulk and
// out-of-pages allocates come from ALLOC. An allocate on an empty list of class c
// first carves a page for c; the first nonzero allocate carves all eight classes.
// One request at a time; req.ready is high in idle, in the cycle after the
// response loads. A full response register holds the sequencer.
// ----------------------------------------------------------------------------
module segregated_pool_allocator_unit import spa_pkg::*; (
  input  logic clk,
  input  logic rst,
  spa_req_if.sink   req,
  spa_rsp_if.source rsp
);

  state_t state, state_next;

  logic              req_op;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;

  logic              heads_valid [NUM_CLASSES];
  logic [ADDR_W-1:0] heads_addr  [NUM_CLASSES];
  logic [USED_W-1:0] pages_used;
  logic              pool_ready;
  logic              init_mode;
  logic [CLS_W-1:0]  carve_cls;
  logic [IDX_W-1:0]  carve_idx;

  logic [CLS_W-1:0]  page_cls [PAGE_LIMIT];
  logic [CLS_W-1:0]  page_rdata;

  logic [LINK_W-1:0] link_rdata;
  link_wr_t          link_wr;
  logic [SLOT_W-1:0] link_raddr;

  logic                  size_big;
  logic [CLS_W-1:0]      alloc_cls;
  logic [HEAD_IDX_W-1:0] alloc_hidx;
  logic [ADDR_W-1:0]     free_blk;
  logic [ADDR_PAGE_W-1:0] free_page;
  logic                  free_in_pool;
  logic                  free_cls_ok;
  logic [ADDR_W-1:0]     free_aligned;
  logic [HEAD_IDX_W-1:0] free_hidx;

  logic [ADDR_W-1:0]     carve_addr;
  logic [ADDR_W-1:0]     carve_next;
  logic [IDX_W:0]        carve_count;
  logic                  carve_last;
  logic [PAGE_SHIFT-1:0] carve_off;

  logic                  out_free;
  logic                  done;
  logic [1:0]            done_status;
  logic [ADDR_W-1:0]     done_addr;
  logic [CLS_W-1:0]      done_cls;
  logic                  carve_go;
  logic [CLS_W-1:0]      carve_go_cls;
  logic                  head_we;
  logic [HEAD_IDX_W-1:0] head_widx;
  logic [LINK_W-1:0]     head_wval;
  logic                  page_we;

  spa_link_mem u_link_mem (
    .clk   (clk),
    .wr    (link_wr),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  assign size_big   = req_size > BULK_LIMIT;
  assign alloc_cls  = class_of(req_size[11:0]);
  assign alloc_hidx = head_index(alloc_cls);
  assign link_raddr = heads_addr[alloc_hidx][MIN_SHIFT +: SLOT_W];

  assign free_blk     = req_addr - HDR_PAD;
  assign free_page    = free_blk[ADDR_W-1:PAGE_SHIFT];
  assign free_in_pool = USED_W'(free_page) < pages_used;
  assign free_cls_ok  = (page_rdata >= CLS_FIRST) && (page_rdata <= CLS_LAST);
  assign free_aligned = free_blk & ~((ADDR_W'(1) << page_rdata) - ADDR_W'(1));
  assign free_hidx    = head_index(page_rdata);

  assign carve_off   = PAGE_SHIFT'(carve_idx) << carve_cls;
  assign carve_addr  = {pages_used[ADDR_PAGE_W-1:0], carve_off};
  assign carve_next  = carve_addr + (ADDR_W'(1) << carve_cls);
  assign carve_count = (IDX_W+1)'(SLOTS_PER_PAGE) >> (carve_cls - CLS_FIRST);
  assign carve_last  = ((IDX_W+1)'(carve_idx) + (IDX_W+1)'(1)) == carve_count;

  // sequencer datapath controls
  always_comb begin
    done         = 1'b0;
    done_status  = STAT_OK;
    done_addr    = '0;
    done_cls     = '0;
    carve_go     = 1'b0;
    carve_go_cls = CLS_FIRST;
    head_we      = 1'b0;
    head_widx    = '0;
    head_wval    = '0;
    page_we      = 1'b0;
    link_wr      = '0;
    unique case (state)
      S_IDLE: ;
      S_DECODE: begin
        if (req_op == OP_ALLOC) begin
          if (req_size == '0) begin
            done        = 1'b1;
            done_status = STAT_NULL;
          end else if (!pool_ready) begin
            carve_go     = 1'b1;
            carve_go_cls = CLS_FIRST;
          end
        end else begin
          if (req_addr == '0) begin
            done        = 1'b1;
            done_status = STAT_NULL;
          end else if (!free_in_pool) begin
            done        = 1'b1;
            done_status = STAT_BULK;
          end
        end
      end
      S_CARVE: begin
        link_wr.we   = 1'b1;
        link_wr.addr = carve_addr[MIN_SHIFT +: SLOT_W];
        link_wr.data = carve_last ? '0 : {1'b1, carve_next};
        if (carve_last) begin
          page_we   = 1'b1;
          head_we   = 1'b1;
          head_widx = head_index(carve_cls);
          head_wval = {1'b1, pages_used[ADDR_PAGE_W-1:0], PAGE_SHIFT'(0)};
          if (init_mode && carve_cls != CLS_LAST) begin
            carve_go     = 1'b1;
            carve_go_cls = carve_cls + CLS_W'(1);
          end
        end
      end
      S_ALLOC: begin
        if (size_big) begin
          done        = 1'b1;
          done_status = STAT_BULK;
        end else if (!heads_valid[alloc_hidx]) begin
          if (pages_used < USED_W'(PAGE_LIMIT)) begin
            carve_go     = 1'b1;
            carve_go_cls = alloc_cls;
          end else begin
            done        = 1'b1;
            done_status = STAT_OOP;
          end
        end
      end
      S_POP: begin
        done      = 1'b1;
        done_addr = heads_addr[alloc_hidx] + HDR_PAD;
        done_cls  = alloc_cls;
        head_we   = out_free;
        head_widx = alloc_hidx;
        head_wval = link_rdata;
      end
      S_FREE: begin
        done = 1'b1;
        if (!free_cls_ok) begin
          done_status = STAT_BULK;
        end else begin
          done_cls     = page_rdata;
          head_we      = out_free;
          head_widx    = free_hidx;
          head_wval    = {1'b1, free_aligned};
          link_wr.we   = out_free;
          link_wr.addr = free_aligned[MIN_SHIFT +: SLOT_W];
          link_wr.data = {heads_valid[free_hidx], heads_addr[free_hidx]};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    if (done) begin
      if (out_free) state_next = S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (req.valid) state_next = S_DECODE;
        S_DECODE: begin
          if (carve_go) begin
            state_next = S_CARVE;
          end else if (req_op == OP_ALLOC) begin
            state_next = S_ALLOC;
          end else begin
            state_next = S_FREE;
          end
        end
        S_CARVE:  if (carve_last && !carve_go) state_next = S_ALLOC;
        S_ALLOC:  state_next = carve_go ? S_CARVE : S_POP;
        S_POP:    state_next = S_IDLE;
        S_FREE:   state_next = S_IDLE;
        default:  state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pages_used <= '0;
      pool_ready <= 1'b0;
      init_mode  <= 1'b0;
      rsp.valid  <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_valid[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (head_we) begin
        heads_valid[head_widx] <= head_wval[ADDR_W];
      end
      if (state == S_DECODE && carve_go) begin
        init_mode <= 1'b1;
      end
      if (state == S_CARVE && carve_last) begin
        pages_used <= pages_used + USED_W'(1);
        if (init_mode && carve_cls == CLS_LAST) begin
          init_mode  <= 1'b0;
          pool_ready <= 1'b1;
        end
      end
      if (done && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op   <= req.operation;
      req_size <= req.request_size;
      req_addr <= req.free_address;
    end
    if (head_we) begin
      heads_addr[head_widx] <= head_wval[ADDR_W-1:0];
    end
    if (carve_go) begin
      carve_cls <= carve_go_cls;
      carve_idx <= '0;
    end else if (state == S_CARVE) begin
      carve_idx <= carve_idx + IDX_W'(1);
    end
    if (done && out_free) begin
      rsp.status         <= done_status;
      rsp.result_address <= done_addr;
      rsp.size_class     <= done_cls;
    end
  end

  // page class table
  always_ff @(posedge clk) begin
    if (page_we) begin
      page_cls[pages_used[PAGE_IDX_W-1:0]] <= carve_cls;
    end
    page_rdata <= page_cls[free_page[PAGE_IDX_W-1:0]];
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: segregated pool allocator testbench
// Sends allocate and free requests over the request channel and scores every
// response against a cycle-free allocator model kept inside the bench.
// Directed corner cases come first, then pool exhaustion with carving in
// every class, then mixed random traffic, stalled on both sides, then unstalled.
// ----------------------------------------------------------------------------
module tb;
  import spa_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [CLS_W-1:0]  cls;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  spa_req_if req();
  spa_rsp_if rsp();

  segregated_pool_allocator_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // allocator model state
  logic [LINK_W-1:0] free_head  [NUM_CLASSES];
  logic [LINK_W-1:0] block_link [LINK_SLOTS];
  logic [CLS_W-1:0]  page_class [PAGE_LIMIT];
  int unsigned       pages_carved;
  bit                pool_seeded;

  alloc_rsp_t        expected_rsp [$];
  logic [ADDR_W-1:0] live_ptr [$];
  logic [ADDR_W-1:0] last_freed;
  bit                idle_on;
  int unsigned       ready_hold;
  int unsigned       mismatch_count;
  int unsigned       requests_sent;
  int unsigned       status_seen [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void carve_page(input int unsigned cls);
    int unsigned base;
    int unsigned bsize;
    int unsigned count;
    base  = pages_carved * PAGE_BYTES;
    bsize = 1 << cls;
    count = PAGE_BYTES >> cls;
    for (int unsigned i = 0; i < count; i++) begin
      block_link[(base + i * bsize) >> MIN_SHIFT] =
        (i + 1 < count) ? {1'b1, ADDR_W'(base + (i + 1) * bsize)} : '0;
    end
    page_class[pages_carved] = CLS_W'(cls);
    free_head[cls - CLS_FIRST] = {1'b1, ADDR_W'(base)};
    pages_carved++;
  endfunction

  function automatic alloc_rsp_t predict_response(input logic op,
                                                  input logic [SIZE_W-1:0] sz,
                                                  input logic [ADDR_W-1:0] fa);
    alloc_rsp_t        r;
    int unsigned       c;
    int unsigned       v;
    int unsigned       pg;
    logic [LINK_W-1:0] head;
    logic [ADDR_W-1:0] blk;
    r = '0;
    r.status = STAT_OK;
    if (op == OP_ALLOC) begin
      if (sz == 0) begin
        r.status = STAT_NULL;
      end else begin
        if (!pool_seeded) begin
          for (c = CLS_FIRST; c <= CLS_LAST; c++) begin
            if (pages_carved < PAGE_LIMIT) carve_page(c);
          end
          pool_seeded = 1'b1;
        end
        if (sz > BULK_LIMIT) begin
          r.status = STAT_BULK;
        end else begin
          c = CLS_FIRST;
          if (sz > 8) begin
            v = sz + 7;
            c = 0;
            while (v != 0) begin
              v = v >> 1;
              c++;
            end
          end
          head = free_head[c - CLS_FIRST];
          if (!head[ADDR_W] && pages_carved < PAGE_LIMIT) begin
            carve_page(c);
            head = free_head[c - CLS_FIRST];
          end
          if (!head[ADDR_W]) begin
            r.status = STAT_OOP;
          end else begin
            blk = head[ADDR_W-1:0];
            free_head[c - CLS_FIRST] = block_link[blk >> MIN_SHIFT];
            r.addr = blk + HDR_PAD;
            r.cls  = CLS_W'(c);
          end
        end
      end
    end else if (fa == 0) begin
      r.status = STAT_NULL;
    end else begin
      blk = fa - HDR_PAD;
      pg  = blk >> PAGE_SHIFT;
      c   = (pg < pages_carved) ? page_class[pg] : 0;
      if (c < CLS_FIRST || c > CLS_LAST) begin
        r.status = STAT_BULK;
      end else begin
        blk = blk & ~ADDR_W'((1 << c) - 1);
        block_link[blk >> MIN_SHIFT] = free_head[c - CLS_FIRST];
        free_head[c - CLS_FIRST] = {1'b1, blk};
        r.cls = CLS_W'(c);
      end
    end
    return r;
  endfunction

  // size that lands in a random class from lo_cls up to the largest
  function automatic logic [SIZE_W-1:0] pick_size(input int unsigned lo_cls);
    int unsigned k;
    k = $urandom_range(lo_cls, CLS_LAST);
    if (k == CLS_FIRST) return $urandom_range(1, 24);
    return $urandom_range((1 << (k - 1)) - 7, (1 << k) - 8);
  endfunction

  task automatic send_request(input logic op, input logic [SIZE_W-1:0] sz,
                              input logic [ADDR_W-1:0] fa, output alloc_rsp_t pred);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.operation    <= op;
    req.request_size <= sz;
    req.free_address <= fa;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pred = predict_response(op, sz, fa);
    expected_rsp.push_back(pred);
    requests_sent++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic free_random_live();
    alloc_rsp_t  r;
    int unsigned idx;
    idx = $urandom_range(0, live_ptr.size() - 1);
    last_freed = live_ptr[idx];
    live_ptr.delete(idx);
    send_request(OP_FREE, $urandom, last_freed, r);
  endtask

  task automatic test_directed_corners();
    alloc_rsp_t r;
    alloc_rsp_t a;
    alloc_rsp_t b;
    // nothing carved yet: null, wrapped and foreign frees, zero-size request
    send_request(OP_FREE, '0, '0, r);
    send_request(OP_FREE, 32'hFFFF_FFFF, 18'd1, r);
    send_request(OP_FREE, '0, 18'h2_0008, r);
    send_request(OP_ALLOC, '0, '0, r);
    // bulk request still seeds the pool
    send_request(OP_ALLOC, 32'hFFFF_FFFF, '0, r);
    send_request(OP_ALLOC, 32'd1, '0, a);
    send_request(OP_ALLOC, 32'd8, '0, b);
    send_request(OP_ALLOC, 32'd9, 18'h3_FFFF, r);
    send_request(OP_ALLOC, 32'd24, '0, r);
    send_request(OP_ALLOC, 32'd25, '0, r);
    send_request(OP_ALLOC, 32'd4088, '0, r);
    send_request(OP_ALLOC, 32'd2040, '0, r);
    send_request(OP_ALLOC, 32'd2041, '0, r);
    send_request(OP_ALLOC, 32'd4089, '0, r);
    send_request(OP_ALLOC, 32'h8000_0000, '0, r);
    send_request(OP_FREE, $urandom, a.addr, r);
    send_request(OP_FREE, '0, b.addr + ADDR_W'(5), r);
    send_request(OP_FREE, '0, a.addr, r);
    send_request(OP_FREE, '0, 18'h3_FFFF, r);
    send_request(OP_FREE, '0, 18'h0_8000, r);
    send_request(OP_ALLOC, 32'd1, '0, r);
    send_request(OP_ALLOC, 32'd1, '0, r);
    wait_drained();
  endtask

  // class 5 may hold a self-looping list after the double free, so the fill
  // uses classes 6 and up to run the page pool dry
  task automatic test_pool_exhaustion();
    alloc_rsp_t  r;
    int unsigned tries;
    tries = 0;
    do begin
      send_request(OP_ALLOC, pick_size(CLS_FIRST + 1), $urandom, r);
      if (r.status == STAT_OK) live_ptr.push_back(r.addr);
      tries++;
    end while (r.status != STAT_OOP && tries < 600);
    repeat (12) begin
      send_request(OP_ALLOC, pick_size(CLS_FIRST), '0, r);
      if (r.status == STAT_OK) live_ptr.push_back(r.addr);
    end
    wait_drained();
    while (live_ptr.size() != 0) free_random_live();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit vary_idle);
    alloc_rsp_t        r;
    logic [ADDR_W-1:0] p;
    int unsigned       pick;
    int unsigned       idx;
    bit                do_free;
    for (int unsigned n = 0; n < count; n++) begin
      if (vary_idle && n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      do_free = live_ptr.size() != 0 &&
                ((pick >= 45 && pick < 89) || (pick < 45 && live_ptr.size() >= 48));
      if (do_free) begin
        idx = $urandom_range(0, live_ptr.size() - 1);
        p = live_ptr[idx];
        live_ptr.delete(idx);
        if (pick >= 85) p = p + ADDR_W'($urandom_range(1, 23));
        last_freed = p;
        send_request(OP_FREE, $urandom, p, r);
      end else if (pick < 89) begin
        send_request(OP_ALLOC, pick_size(CLS_FIRST), $urandom, r);
        if (r.status == STAT_OK) live_ptr.push_back(r.addr);
      end else if (pick < 91) begin
        send_request(OP_FREE, $urandom, last_freed, r);
      end else if (pick < 94) begin
        send_request(OP_FREE, $urandom, ADDR_W'($urandom), r);
      end else if (pick < 96) begin
        send_request((pick == 94) ? OP_ALLOC : OP_FREE, '0, '0, r);
      end else begin
        send_request(OP_ALLOC, $urandom_range(4089, 32'hFFFF_FFFF), $urandom, r);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("response with no request pending: status %0d address %0h class %0d",
               rsp.status, rsp.result_address, rsp.size_class);
        mismatch_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.result_address !== want.addr) begin
          $error("result_address: expected %0h, got %0h", want.addr, rsp.result_address);
          mismatch_count++;
        end
        if (rsp.size_class !== want.cls) begin
          $error("size_class: expected %0d, got %0d", want.cls, rsp.size_class);
          mismatch_count++;
        end
        status_seen[want.status]++;
      end
    end
    if (ready_hold != 0) ready_hold--;
    else if (idle_on && $urandom_range(0, 7) == 0) ready_hold = $urandom_range(1, 11);
    rsp.ready <= (ready_hold == 0);
  end

  initial begin
    req.valid        = 1'b0;
    req.operation    = OP_ALLOC;
    req.request_size = '0;
    req.free_address = '0;
    rsp.ready        = 1'b0;
    rst              = 1'b1;
    foreach (free_head[i]) free_head[i] = '0;
    foreach (block_link[i]) block_link[i] = '0;
    foreach (page_class[i]) page_class[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    pages_carved   = 0;
    pool_seeded    = 1'b0;
    last_freed     = '0;
    idle_on        = 1'b1;
    ready_hold     = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_pool_exhaustion();
    test_random_traffic(250, 1'b1);
    idle_on = 1'b0;
    test_random_traffic(150, 1'b0);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests: %0d ok, %0d null, %0d bulk, %0d out of pages",
             requests_sent, status_seen[STAT_OK], status_seen[STAT_NULL],
             status_seen[STAT_BULK], status_seen[STAT_OOP]);
    $display("Pages carved: %0d of %0d", pages_carved, PAGE_LIMIT);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
